[rtl/reed_muller_generator_rows_core_defines.svh]
// assertion macros for the reed-muller generator row core
// expects clk and arst_n in the scope of use
`ifndef REED_MULLER_GENERATOR_ROWS_CORE_DEFINES_SVH
`define REED_MULLER_GENERATOR_ROWS_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define RMG_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rmg assertion failed");
`define RMG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rmg assertion failed");
`else
`define RMG_ASSERT_IMPL(lbl, ante, cons)
`define RMG_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/rmg_pkg.sv]
// shared types, constants and row functions for the reed-muller row generator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rmg_pkg;

	localparam int MAX_VARS  = 6;
	localparam int VAR_W     = 3;
	localparam int MASK_W    = MAX_VARS;
	localparam int ROW_W     = 1 << MAX_VARS;
	localparam int IDX_W     = MAX_VARS;
	localparam int REQ_DEPTH = 2;
	localparam int PTR_W     = (REQ_DEPTH > 1) ? $clog2(REQ_DEPTH) : 1;
	localparam int CNT_W     = $clog2(REQ_DEPTH + 1);

	typedef struct packed {
		logic [VAR_W-1:0]  order;
		logic [VAR_W-1:0]  vars;
		logic [MASK_W-1:0] last_mask;
	} req_t;

	typedef struct packed {
		logic valid;
		req_t req;
	} push_t;

	typedef struct packed {
		logic full;
		logic empty;
		req_t head;
	} fifo_stat_t;

	typedef struct packed {
		logic busy;
		logic pop;
	} back_stat_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} back_state_t;

	function automatic logic [VAR_W:0] popcount(input logic [MASK_W-1:0] mask);
		logic [VAR_W:0] n;
		n = '0;
		for (int i = 0; i < MASK_W; i++) begin
			n = n + {{VAR_W{1'b0}}, mask[i]};
		end
		return n;
	endfunction

	// highest subset of size order: the top order variables of vars
	function automatic logic [MASK_W-1:0] top_mask(input logic [VAR_W-1:0] order,
			input logic [VAR_W-1:0] vars);
		logic [MASK_W-1:0] m;
		m = '0;
		for (int i = 0; i < MASK_W; i++) begin
			m[i] = (i < int'(vars)) && (i >= int'(vars) - int'(order));
		end
		return m;
	endfunction

	// monomial row: column j set when j is below 2**vars and all variables of mask are one in j
	function automatic logic [ROW_W-1:0] mono_row(input logic [MASK_W-1:0] mask,
			input logic [VAR_W-1:0] vars);
		logic [ROW_W-1:0] row;
		logic [MASK_W:0]  jv;
		row = '0;
		for (int j = 0; j < ROW_W; j++) begin
			jv = (MASK_W + 1)'(j);
			row[j] = ((jv >> vars) == '0) && ((jv[MASK_W-1:0] & mask) == mask);
		end
		return row;
	endfunction

endpackage

`default_nettype wire

[rtl/rmg_front.sv]
// request intake: clamps order and variable count, precomputes the final subset
// depends on rmg_pkg
`timescale 1ns / 1ps
`default_nettype none

module rmg_front import rmg_pkg::*; (
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  wire logic [VAR_W-1:0] order_r,
	input  wire logic [VAR_W-1:0] num_vars_m,
	input  wire logic             fifo_full,
	output push_t                 push
);

	logic [VAR_W-1:0] vars_c;
	logic [VAR_W-1:0] order_c;

	always_comb begin
		vars_c  = (num_vars_m > VAR_W'(MAX_VARS)) ? VAR_W'(MAX_VARS) : num_vars_m;
		order_c = (order_r > vars_c) ? vars_c : order_r;
	end

	assign req_stall               = fifo_full;
	assign push.valid              = req_valid && !fifo_full;
	assign push.req.order          = order_c;
	assign push.req.vars           = vars_c;
	assign push.req.last_mask      = top_mask(order_c, vars_c);

endmodule

`default_nettype wire

[rtl/rmg_req_fifo.sv]
// short request queue between intake and row scan
// depends on rmg_pkg
`timescale 1ns / 1ps
`default_nettype none

module rmg_req_fifo import rmg_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	input  wire logic  pop,
	output fifo_stat_t stat
);

	req_t             mem_q [REQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full  = (count_q == CNT_W'(REQ_DEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.head  = mem_q[rd_ptr_q];
	assign do_push    = push.valid && !stat.full;
	assign do_pop     = pop && !stat.empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(REQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(REQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/rmg_back.sv]
// row scan: walks variable subsets in increasing order, emits those within the order
// depends on rmg_pkg
`timescale 1ns / 1ps
`default_nettype none

module rmg_back import rmg_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fifo_stat_t        fifo_stat,
	output back_stat_t             stat,
	output logic                   row_valid,
	input  wire logic              row_stall,
	output logic [ROW_W-1:0]       row_bits,
	output logic [IDX_W-1:0]       row_index,
	output logic                   last_row
);

	back_state_t       state_q;
	back_state_t       state_d;
	req_t              cur_q;
	logic [MASK_W-1:0] mask_q;
	logic [IDX_W-1:0]  idx_q;
	logic              out_valid_q;
	logic [ROW_W-1:0]  row_q;
	logic [IDX_W-1:0]  index_q;
	logic              last_q;

	logic in_order;
	logic out_free;
	logic is_last;
	logic load_out;
	logic advance;

	always_comb begin
		in_order = popcount(mask_q) <= {1'b0, cur_q.order};
		out_free = !out_valid_q || !row_stall;
		is_last  = (mask_q == cur_q.last_mask);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (!fifo_stat.empty) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (in_order && out_free && is_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		stat.pop  = 1'b0;
		stat.busy = 1'b0;
		load_out  = 1'b0;
		advance   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				stat.pop = !fifo_stat.empty;
			end
			ST_SCAN: begin
				stat.busy = 1'b1;
				load_out  = in_order && out_free;
				// subsets above the order are skipped without using the output
				advance   = !in_order || out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!row_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stat.pop) begin
			cur_q  <= fifo_stat.head;
			mask_q <= '0;
			idx_q  <= '0;
		end else begin
			if (advance) mask_q <= mask_q + 1'b1;
			if (load_out) idx_q <= idx_q + 1'b1;
		end
		if (load_out) begin
			row_q   <= mono_row(mask_q, cur_q.vars);
			index_q <= idx_q;
			last_q  <= is_last;
		end
	end

	assign row_valid = out_valid_q;
	assign row_bits  = row_q;
	assign row_index = index_q;
	assign last_row  = last_q;

endmodule

`default_nettype wire

[rtl/reed_muller_generator_rows_core.sv]
// top level of the reed-muller generator row core: intake, request queue, row scan
// depends on rmg_pkg, rmg_front, rmg_req_fifo, rmg_back and the defines header
//
// channel  direction  handshake             payload
// request  in         req_valid / req_stall order_r, num_vars_m
// row      out        row_valid / row_stall row_bits, row_index, last_row
//
// a request leaves the queue once the scan is idle, then the scan counter walks the variable
// subsets from the empty one up to the last one of size r, one per cycle while the output is free.
// rows leave at most one per cycle from the output register; a held row stalls the scan.
// up to two requests wait in the queue while a scan runs.
// reset clears the queue, the scan state and the output valid.
`timescale 1ns / 1ps
`default_nettype none
`include "reed_muller_generator_rows_core_defines.svh"

module reed_muller_generator_rows_core import rmg_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  wire logic [VAR_W-1:0] order_r,
	input  wire logic [VAR_W-1:0] num_vars_m,
	output logic                  row_valid,
	input  wire logic             row_stall,
	output logic [ROW_W-1:0]      row_bits,
	output logic [IDX_W-1:0]      row_index,
	output logic                  last_row
);

	push_t      push;
	fifo_stat_t fifo_stat;
	back_stat_t back_stat;

	rmg_front u_front (
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.order_r    (order_r),
		.num_vars_m (num_vars_m),
		.fifo_full  (fifo_stat.full),
		.push       (push)
	);

	rmg_req_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (back_stat.pop),
		.stat   (fifo_stat)
	);

	rmg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fifo_stat (fifo_stat),
		.stat      (back_stat),
		.row_valid (row_valid),
		.row_stall (row_stall),
		.row_bits  (row_bits),
		.row_index (row_index),
		.last_row  (last_row)
	);

	// only the empty subset covers column zero, and it is always the first row
	`RMG_ASSERT_IMPL(a_col0_first, row_valid, row_bits[0] == (row_index == '0))
	// a pending row that is not the last means the scan is still running
	`RMG_ASSERT_IMPL(a_scan_busy, row_valid && !last_row, back_stat.busy)
	`RMG_ASSERT_IMPL(a_pop_nonempty, back_stat.pop, !fifo_stat.empty)
	`RMG_ASSERT_NEXT(a_push_lands, req_valid && !req_stall, !fifo_stat.empty)

endmodule

`default_nettype wire
